@@ hdl/nearest_palette_color_search_assert.svh @@
// Assertion macros shared by the palette search RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define NPCS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be true outside reset.
`define NPCS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ hdl/npcs_pkg.sv @@
// Shared types, widths and the constant palette table for the palette search block.
// No dependencies; imported by every module of the block.
package npcs_pkg;

    localparam int RGB_W           = 24;
    localparam int SLOT_W          = 4;
    localparam int INDEX_W         = 8;
    localparam int DIST_W          = 18;
    localparam int PALETTE_SIZE    = 256;
    localparam int DEFAULT_ENTRIES = 256;
    localparam int QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic [RGB_W-1:0]  target_rgb;
        logic [SLOT_W-1:0] slot;
    } t_item;

    // Head of the input queue as seen by the search engine.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DRAIN  = 3'b100
    } t_state;

    typedef logic [PALETTE_SIZE-1:0][RGB_W-1:0] t_rom;

    // Terminal-style table: base colors, bright colors, 6x6x6 cube, gray ramp.
    function automatic t_rom build_palette();
        t_rom       rom;
        int         n;
        logic [7:0] lv;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            if (i < 8) begin
                rom[i] = '0;
                if (i % 2 == 1)       rom[i][23:16] = 8'haa;
                if ((i / 2) % 2 == 1) rom[i][15:8]  = 8'haa;
                if ((i / 4) % 2 == 1) rom[i][7:0]   = 8'haa;
            end else if (i < 16) begin
                rom[i] = 24'h555555;
                if (i % 2 == 1)       rom[i][23:16] = 8'hff;
                if ((i / 2) % 2 == 1) rom[i][15:8]  = 8'hff;
                if ((i / 4) % 2 == 1) rom[i][7:0]   = 8'hff;
            end else if (i < 232) begin
                n = i - 16;
                rom[i][23:16] = 8'((n / 36) * 85 / 2);
                rom[i][15:8]  = 8'(((n / 6) % 6) * 85 / 2);
                rom[i][7:0]   = 8'((n % 6) * 85 / 2);
            end else begin
                lv     = 8'(i * 10 - 2312);
                rom[i] = {lv, lv, lv};
            end
        end
        return rom;
    endfunction

    localparam t_rom PALETTE_ROM = build_palette();

endpackage

@@ hdl/npcs_front.sv @@
// Input side of the palette search: accepts transactions into a short queue.
// Depends on npcs_pkg and the shared assertion macros.
`include "nearest_palette_color_search_assert.svh"

module npcs_front
    import npcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output t_queue_head o_head,
    input  logic        i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_push;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push  = i_valid && o_ready;

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `NPCS_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && (r_count == '0), "pop from empty queue")

endmodule

@@ hdl/npcs_search.sv @@
// Search engine: walks the palette one entry per cycle and keeps the nearest one.
// Depends on npcs_pkg (palette table, types) and the shared assertion macros.
`include "nearest_palette_color_search_assert.svh"

module npcs_search
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEFAULT_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_queue_head         i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [INDEX_W-1:0]  o_best_index,
    output logic                o_exact_match,
    output logic [DIST_W-1:0]   o_best_distance
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx;
    logic [RGB_W-1:0]   r_target;
    logic [SLOT_W-1:0]  r_slot;

    // distance stage
    logic               r_d_valid;
    logic [DIST_W-1:0]  r_d;
    logic [IDX_W-1:0]   r_d_idx;

    // running best
    logic               r_have;
    logic [DIST_W-1:0]  r_best_d;
    logic [IDX_W-1:0]   r_best_idx;

    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [IDX_W-1:0]   r_out_idx;
    logic [DIST_W-1:0]  r_out_d;

    logic [RGB_W-1:0]   w_pal;
    logic signed [8:0]  w_dr, w_dg, w_db;
    logic signed [17:0] w_sq_r, w_sq_g, w_sq_b;
    logic [DIST_W-1:0]  w_dist;
    logic               w_upd;
    logic [DIST_W-1:0]  n_best_d;
    logic [IDX_W-1:0]   n_best_idx;
    logic               w_out_free;
    logic               w_load_out;

    // Palette lookup and squared distance for the current index.
    assign w_pal  = PALETTE_ROM[8'(r_idx)];
    assign w_dr   = $signed({1'b0, w_pal[23:16]}) - $signed({1'b0, r_target[23:16]});
    assign w_dg   = $signed({1'b0, w_pal[15:8]})  - $signed({1'b0, r_target[15:8]});
    assign w_db   = $signed({1'b0, w_pal[7:0]})   - $signed({1'b0, r_target[7:0]});
    assign w_sq_r = w_dr * w_dr;
    assign w_sq_g = w_dg * w_dg;
    assign w_sq_b = w_db * w_db;
    assign w_dist = {2'b00, w_sq_r[15:0]} + {2'b00, w_sq_g[15:0]} + {2'b00, w_sq_b[15:0]};

    // Strict less-than keeps the lowest index on ties.
    assign w_upd      = r_d_valid && (!r_have || (r_d < r_best_d));
    assign n_best_d   = w_upd ? r_d : r_best_d;
    assign n_best_idx = w_upd ? r_d_idx : r_best_idx;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_load_out = (r_state == ST_DRAIN) && w_out_free;
    assign o_pop      = (r_state == ST_IDLE) && i_head.valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (r_idx == LAST_IDX) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_d_valid   <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state   <= n_state;
            r_d_valid <= (r_state == ST_SEARCH);
            if (o_pop) begin
                r_have <= 1'b0;
                r_idx  <= '0;
            end else begin
                if (w_upd) r_have <= 1'b1;
                if (r_state == ST_SEARCH) r_idx <= r_idx + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_target <= i_head.item.target_rgb;
            r_slot   <= i_head.item.slot;
        end
        r_d        <= w_dist;
        r_d_idx    <= r_idx;
        r_best_d   <= n_best_d;
        r_best_idx <= n_best_idx;
        if (w_load_out) begin
            r_out_slot <= r_slot;
            r_out_idx  <= n_best_idx;
            r_out_d    <= n_best_d;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_slot_out      = r_out_slot;
    assign o_best_index    = INDEX_W'(r_out_idx);
    assign o_best_distance = r_out_d;
    assign o_exact_match   = (r_out_d == '0);

    `NPCS_ASSERT(a_search_feeds_compare, i_clk, i_rst_n, (r_state == ST_SEARCH) |=> r_d_valid, "distance stage idle during search")
    `NPCS_ASSERT(a_drain_empties_stage, i_clk, i_rst_n, (r_state == ST_DRAIN) |=> !r_d_valid, "distance stage busy after drain")
    `NPCS_ASSERT(a_index_in_range, i_clk, i_rst_n, o_valid |-> (o_best_index <= INDEX_W'(PALETTE_ENTRIES - 1)), "result index beyond searched entries")

endmodule

@@ hdl/nearest_palette_color_search.sv @@
// Top level of the nearest palette color search block.
// Depends on npcs_pkg, npcs_front (input queue) and npcs_search (search engine).

// Finds the palette entry nearest to a 24-bit RGB target by squared Euclidean
// distance over the first PALETTE_ENTRIES entries of the 256-color terminal-style
// table, lowest index on ties, and returns it with the echoed slot,
// the distance and an exact-match flag. The search engine pops a transaction
// in its idle state, sends one palette entry per cycle through the single
// distance unit in its search state, and in its drain state hands the result
// to the output register once that register is free. A two-entry input queue
// keeps accepting while a search runs, and the output register holds a
// finished result while the next search proceeds.
module nearest_palette_color_search
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEFAULT_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [RGB_W-1:0]    i_target_rgb,
    input  logic [SLOT_W-1:0]   i_slot,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [INDEX_W-1:0]  o_best_index,
    output logic                o_exact_match,
    output logic [DIST_W-1:0]   o_best_distance
);

    t_item       w_item;
    t_queue_head w_head;
    logic        w_pop;

    assign w_item.target_rgb = i_target_rgb;
    assign w_item.slot       = i_slot;

    npcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (w_item),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    npcs_search #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_search (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_slot_out      (o_slot_out),
        .o_best_index    (o_best_index),
        .o_exact_match   (o_exact_match),
        .o_best_distance (o_best_distance)
    );

endmodule

@@ tb/tb_nearest_palette_color_search.sv @@
// Testbench for nearest_palette_color_search: directed table, then random colors under several
// sender/receiver idle mixes, results checked against hand values or local nearest-color search.
// Depends on npcs_pkg and the nearest_palette_color_search RTL.
`timescale 1ns / 100ps

module tb_nearest_palette_color_search;
    import npcs_pkg::*;

    localparam int N_ENTRIES    = DEFAULT_ENTRIES;
    localparam int N_SEARCH     = (N_ENTRIES > 256) ? 256 : N_ENTRIES;
    localparam int ITEMS_RANDOM = 1228;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct {
        logic [SLOT_W-1:0]  slot;
        logic [INDEX_W-1:0] index;
        logic               exact;
        logic [DIST_W-1:0]  dist_sq;
    } t_match;

    typedef struct {
        logic [RGB_W-1:0]   rgb;
        logic [SLOT_W-1:0]  slot;
        bit                 typed;   // expected values below are filled in by hand
        logic [INDEX_W-1:0] index;
        logic               exact;
        logic [DIST_W-1:0]  dist_sq;
    } t_probe;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [RGB_W-1:0]   i_target_rgb;
    logic [SLOT_W-1:0]  i_slot;
    logic               o_valid;
    logic               i_ready;
    logic [SLOT_W-1:0]  o_slot_out;
    logic [INDEX_W-1:0] o_best_index;
    logic               o_exact_match;
    logic [DIST_W-1:0]  o_best_distance;

    logic [RGB_W-1:0] term_colors [256];
    t_match           pending_results [$];

    int fail_count;
    int checked_count;
    int exact_count;
    int sent_count;
    int cycle_count;
    int src_gap_pct;
    int sink_stall_pct;

    nearest_palette_color_search #(
        .PALETTE_ENTRIES(N_ENTRIES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_target_rgb   (i_target_rgb),
        .i_slot         (i_slot),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_slot_out     (o_slot_out),
        .o_best_index   (o_best_index),
        .o_exact_match  (o_exact_match),
        .o_best_distance(o_best_distance)
    );

    // Directed colors: extremes, exact hits in every table region, ties across regions.
    t_probe directed [] = '{
        '{24'h000000, 4'd0,  1'b1, 8'd0,   1'b1, 18'd0},  // ties with cube black, lowest wins
        '{24'hffffff, 4'd15, 1'b1, 8'd15,  1'b1, 18'd0},
        '{24'haa0000, 4'd1,  1'b1, 8'd1,   1'b1, 18'd0},
        '{24'h00aa00, 4'd2,  1'b1, 8'd2,   1'b1, 18'd0},
        '{24'h0000aa, 4'd4,  1'b1, 8'd4,   1'b1, 18'd0},
        '{24'haaaaaa, 4'd7,  1'b1, 8'd7,   1'b1, 18'd0},  // also a cube entry
        '{24'h555555, 4'd8,  1'b1, 8'd8,   1'b1, 18'd0},  // also a cube entry
        '{24'hff5555, 4'd9,  1'b1, 8'd9,   1'b1, 18'd0},
        '{24'h55ffff, 4'd14, 1'b1, 8'd14,  1'b1, 18'd0},
        '{24'h080808, 4'd3,  1'b1, 8'd232, 1'b1, 18'd0},
        '{24'heeeeee, 4'd12, 1'b1, 8'd255, 1'b1, 18'd0},
        '{24'h808080, 4'd0,  1'b1, 8'd244, 1'b1, 18'd0},
        '{24'h2a2a2a, 4'd6,  1'b1, 8'd59,  1'b1, 18'd0},
        '{24'hd4d4d4, 4'd9,  1'b1, 8'd231, 1'b1, 18'd0},
        '{24'h000001, 4'd5,  1'b1, 8'd0,   1'b0, 18'd1},
        '{24'hfffffe, 4'd6,  1'b1, 8'd15,  1'b0, 18'd1},
        '{24'hff0000, 4'd10, 1'b0, 8'd0,   1'b0, 18'd0},
        '{24'h00ff00, 4'd11, 1'b0, 8'd0,   1'b0, 18'd0},
        '{24'h0000ff, 4'd13, 1'b0, 8'd0,   1'b0, 18'd0},
        '{24'h7f8081, 4'd14, 1'b0, 8'd0,   1'b0, 18'd0},
        '{24'h123456, 4'd10, 1'b0, 8'd0,   1'b0, 18'd0},
        '{24'ha5a5a5, 4'd11, 1'b0, 8'd0,   1'b0, 18'd0},
        '{24'h5a5a5a, 4'd13, 1'b0, 8'd0,   1'b0, 18'd0},
        '{24'hff00ff, 4'd15, 1'b0, 8'd0,   1'b0, 18'd0}
    };

    function automatic logic [RGB_W-1:0] table_color(int idx);
        int         lv [6] = '{0, 42, 85, 127, 170, 212};
        int         c;
        logic [7:0] g;
        if (idx < 8) begin
            return {idx[0] ? 8'haa : 8'h00, idx[1] ? 8'haa : 8'h00, idx[2] ? 8'haa : 8'h00};
        end else if (idx < 16) begin
            return {idx[0] ? 8'hff : 8'h55, idx[1] ? 8'hff : 8'h55, idx[2] ? 8'hff : 8'h55};
        end else if (idx < 232) begin
            c = idx - 16;
            return {8'(lv[c / 36]), 8'(lv[(c / 6) % 6]), 8'(lv[c % 6])};
        end
        g = 8'(idx * 10 - 2312);
        return {g, g, g};
    endfunction

    function automatic int chan_sq(logic [7:0] a, logic [7:0] b);
        int x;
        int y;
        x = a;
        y = b;
        return (x - y) * (x - y);
    endfunction

    function automatic t_match nearest_entry(logic [RGB_W-1:0] rgb, logic [SLOT_W-1:0] slot);
        t_match           m;
        int               d;
        int               best_d;
        int               best_i;
        logic [RGB_W-1:0] p;
        best_d = 0;
        best_i = 0;
        for (int i = 0; i < N_SEARCH; i++) begin
            p = term_colors[i];
            d = chan_sq(p[23:16], rgb[23:16]) + chan_sq(p[15:8], rgb[15:8])
                + chan_sq(p[7:0], rgb[7:0]);
            // strict compare keeps the lowest index on ties
            if (i == 0 || d < best_d) begin
                best_d = d;
                best_i = i;
            end
        end
        m.slot    = slot;
        m.index   = INDEX_W'(best_i);
        m.exact   = (best_d == 0);
        m.dist_sq = DIST_W'(best_d);
        return m;
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // Present one transaction after a random gap, hold until accepted, queue its result.
    task automatic send_color(logic [RGB_W-1:0] rgb, logic [SLOT_W-1:0] slot,
                              bit typed, t_match known);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_target_rgb <= rgb;
        i_slot       <= slot;
        do @(posedge i_clk); while (!o_ready);
        if (typed)
            pending_results.push_back(known);
        else
            pending_results.push_back(nearest_entry(rgb, slot));
        sent_count++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic random_phase(int gap_pct, int stall_pct, int count);
        logic [RGB_W-1:0] rgb;
        t_match           none;
        int               pick;
        none = '{default: '0};
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                rgb = RGB_W'($urandom);
            else if (pick < 75)
                rgb = term_colors[$urandom_range(0, N_SEARCH - 1)];
            else
                rgb = term_colors[$urandom_range(0, N_SEARCH - 1)] ^ RGB_W'($urandom & 24'h070707);
            send_color(rgb, SLOT_W'($urandom), 1'b0, none);
        end
        drain_results();
    endtask

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result slot=%0d index=%0d",
                                       o_slot_out, o_best_index));
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (o_exact_match) exact_count++;
                if (o_slot_out !== want.slot)
                    note_failure($sformatf("slot_out got %0d want %0d", o_slot_out, want.slot));
                if (o_best_index !== want.index)
                    note_failure($sformatf("best_index got %0d want %0d",
                                           o_best_index, want.index));
                if (o_exact_match !== want.exact)
                    note_failure($sformatf("exact_match got %0b want %0b",
                                           o_exact_match, want.exact));
                if (o_best_distance !== want.dist_sq)
                    note_failure($sformatf("best_distance got %0d want %0d",
                                           o_best_distance, want.dist_sq));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_match known;
        int     settle;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_target_rgb   = '0;
        i_slot         = '0;
        fail_count     = 0;
        checked_count  = 0;
        exact_count    = 0;
        sent_count     = 0;
        cycle_count    = 0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < 256; i++)
            term_colors[i] = (i < N_SEARCH) ? table_color(i) : '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[r]) begin
            known.slot    = directed[r].slot;
            known.index   = directed[r].index;
            known.exact   = directed[r].exact;
            known.dist_sq = directed[r].dist_sq;
            send_color(directed[r].rgb, directed[r].slot, directed[r].typed, known);
        end
        drain_results();

        random_phase(0,  0,  ITEMS_RANDOM / 4);
        random_phase(85, 0,  ITEMS_RANDOM / 4);
        random_phase(0,  85, ITEMS_RANDOM / 4);
        random_phase(28, 28, ITEMS_RANDOM - 3 * (ITEMS_RANDOM / 4));

        while (pending_results.size() != 0) @(posedge i_clk);
        settle = 0;
        while (settle < N_SEARCH + 8) begin
            @(posedge i_clk);
            settle++;
        end

        $display("%0d transactions sent (%0d directed), %0d results checked, %0d exact hits",
                 sent_count, directed.size(), checked_count, exact_count);
        $display("random colors ran under no idling, sender gaps, receiver stalls and both");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
